[hw/rtl/hlsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hlsr_pkg;

  localparam int MAX_LEVEL = 10;
  localparam int TIME_BITS = 32;

  localparam int LEVEL_W   = 4;
  localparam int STEPS_W   = 8;
  localparam int MS_PER_S  = 1000;
  localparam int NEED_W    = 26;
  localparam int CMP_W     = (TIME_BITS > NEED_W) ? TIME_BITS : NEED_W;
  localparam int WINDOW_MS = 15 * 60 * 1000;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    OP_SAMPLE      = 2'd0,
    OP_REGULATE    = 2'd1,
    OP_MANUAL_UP   = 2'd2,
    OP_MANUAL_DOWN = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_OFF      = 3'd0,
    PH_PREHEAT  = 3'd1,
    PH_HEATING  = 3'd2,
    PH_COOLDOWN = 3'd3,
    PH_FAULT    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    CFG_SETPOINT      = 3'd0,
    CFG_COLD_MARGIN   = 3'd1,
    CFG_HOT_MARGIN    = 3'd2,
    CFG_MIN_STEP_INTV = 3'd3,
    CFG_STABILIZE_DUR = 3'd4,
    CFG_STEP_QUOTA    = 3'd5,
    CFG_EXH_WARN_LIM  = 3'd6,
    CFG_EXH_OFF_LIM   = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_COMMIT = 1'b1
  } bk_state_e;

  typedef struct packed {
    logic [8:0]         setpoint;
    logic [7:0]         cold_margin;
    logic [7:0]         hot_margin;
    logic [15:0]        min_step_interval_s;
    logic [15:0]        stabilize_duration_s;
    logic [7:0]         step_quota;
    logic signed [11:0] exh_warn_lim;
    logic signed [11:0] exh_off_lim;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    setpoint:             9'd336,
    cold_margin:          8'd8,
    hot_margin:           8'd16,
    min_step_interval_s:  16'd60,
    stabilize_duration_s: 16'd300,
    step_quota:           8'd4,
    exh_warn_lim:         12'sd1280,
    exh_off_lim:          12'sd1920
  };

  // One classified word as it waits between the front and the back.
  typedef struct packed {
    op_e                op;
    time_t              now;
    phase_e             phase;
    logic               shut;
    logic               warn;
    logic               inv;
    logic               cold;
    logic               hot;
    logic               at_target;
    logic [NEED_W-1:0]  need_ms;
    logic [NEED_W-1:0]  stab_ms;
    logic [STEPS_W-1:0] max_steps;
  } item_t;

endpackage

`default_nettype wire

[hw/rtl/hlsr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module hlsr_front
  import hlsr_pkg::*;
(
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [31:0]        time_ms_i,
  input  wire logic signed [11:0] inside_temp_i,
  input  wire logic               inside_valid_i,
  input  wire logic signed [11:0] exhaust_temp_i,
  input  wire logic               exhaust_valid_i,
  input  wire logic signed [15:0] heater_current_i,
  input  wire cfg_t               cfg_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output item_t                   item_o
);

  phase_e            phase;
  logic              over_off;
  logic              over_warn;
  logic signed [13:0] ins_x;
  logic signed [13:0] tgt_x;
  logic signed [13:0] lo_x;
  logic signed [13:0] hi_x;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    phase = PH_FAULT;
    if (heater_current_i < 16'sd200) begin
      phase = PH_OFF;
    end else if (heater_current_i > 16'sd5000 &&
                 (!exhaust_valid_i || exhaust_temp_i < 12'sd640)) begin
      phase = PH_PREHEAT;
    end else if (heater_current_i > 16'sd1000 &&
                 (!exhaust_valid_i || exhaust_temp_i >= 12'sd640)) begin
      phase = PH_HEATING;
    end else if (heater_current_i >= 16'sd300 && heater_current_i < 16'sd1000 &&
                 (!exhaust_valid_i || exhaust_temp_i < 12'sd800)) begin
      phase = PH_COOLDOWN;
    end
  end

  assign over_off  = exhaust_valid_i && (exhaust_temp_i > cfg_i.exh_off_lim);
  assign over_warn = exhaust_valid_i && (exhaust_temp_i > cfg_i.exh_warn_lim);

  assign ins_x = 14'(inside_temp_i);
  assign tgt_x = signed'({5'b0, cfg_i.setpoint});
  assign lo_x  = tgt_x - signed'({6'b0, cfg_i.cold_margin});
  assign hi_x  = tgt_x + signed'({6'b0, cfg_i.hot_margin});

  always_comb begin
    item_o.op        = op_e'(operation_i);
    item_o.now       = TIME_BITS'(time_ms_i);
    item_o.phase     = phase;
    item_o.shut      = over_off;
    item_o.warn      = over_warn && !over_off;
    item_o.inv       = inside_valid_i;
    item_o.cold      = ins_x < lo_x;
    item_o.hot       = ins_x > hi_x;
    item_o.at_target = ins_x >= tgt_x;
    item_o.need_ms   = NEED_W'(cfg_i.min_step_interval_s) * NEED_W'(MS_PER_S);
    item_o.stab_ms   = NEED_W'(cfg_i.stabilize_duration_s) * NEED_W'(MS_PER_S);
    item_o.max_steps = cfg_i.step_quota;
  end

endmodule

`default_nettype wire

[hw/rtl/hlsr_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module hlsr_fifo
  import hlsr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      item_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue read while empty");

endmodule

`default_nettype wire

[hw/rtl/hlsr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module hlsr_back
  import hlsr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire item_t item_i,
  input  wire logic  empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [3:0] heater_level_o,
  output logic [2:0] heater_phase_o,
  output logic       pulse_up_o,
  output logic       pulse_down_o,
  output logic       shutdown_request_o
);

  localparam logic [LEVEL_W-1:0] LevelMin  = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LevelMax  = LEVEL_W'(MAX_LEVEL);
  localparam logic [STEPS_W-1:0] StepsSat  = '1;

  bk_state_e state_q, state_d;
  logic      eval_en;
  logic      commit;

  logic [LEVEL_W-1:0] level_q, level_d;
  phase_e             phase_q, phase_d;
  time_t              last_q, last_d;
  logic [STEPS_W-1:0] wsteps_q, wsteps_d;
  time_t              wstart_q, wstart_d;
  time_t              stable_q, stable_d;

  logic renew_q, intv_ok_q, stab_due_q;
  logic renew_d, intv_ok_d, stab_due_d;

  logic [STEPS_W-1:0] steps_eff;
  logic step_up, step_dn, up, dn, shut;

  logic               out_valid_q;
  logic [LEVEL_W-1:0] out_level_q;
  phase_e             out_phase_q;
  logic               out_up_q, out_dn_q, out_shut_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) state_d = BK_COMMIT;
      end
      BK_COMMIT: begin
        if (commit) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs: evaluate the timers, then commit once the output is free.
  always_comb begin
    eval_en = 1'b0;
    commit  = 1'b0;
    case (state_q)
      BK_IDLE:   eval_en = !empty_i;
      BK_COMMIT: commit  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign pop_o = commit;

  always_comb begin
    renew_d    = (wstart_q == '0) ||
                 (CMP_W'(time_t'(item_i.now - wstart_q)) > CMP_W'(WINDOW_MS));
    intv_ok_d  = CMP_W'(time_t'(item_i.now - last_q)) >= CMP_W'(item_i.need_ms);
    stab_due_d = CMP_W'(time_t'(item_i.now - stable_q)) >= CMP_W'(item_i.stab_ms);
  end

  always_comb begin
    level_d   = level_q;
    phase_d   = phase_q;
    last_d    = last_q;
    wsteps_d  = wsteps_q;
    wstart_d  = wstart_q;
    stable_d  = stable_q;
    steps_eff = wsteps_q;
    step_up   = 1'b0;
    step_dn   = 1'b0;
    up        = 1'b0;
    dn        = 1'b0;
    shut      = 1'b0;
    case (item_i.op)
      OP_SAMPLE: begin
        phase_d = item_i.phase;
        if (item_i.shut) begin
          shut = 1'b1;
        end else if (item_i.warn && level_q > LevelMin) begin
          level_d = level_q - 1'b1;
          dn      = 1'b1;
        end
      end
      OP_REGULATE: begin
        if (renew_q) begin
          steps_eff = '0;
          wsteps_d  = '0;
          wstart_d  = item_i.now;
        end
        if (phase_q == PH_HEATING && steps_eff < item_i.max_steps &&
            intv_ok_q && item_i.inv) begin
          if (item_i.cold) begin
            step_up = 1'b1;
          end else if (item_i.hot) begin
            step_dn = 1'b1;
          end else if (item_i.at_target) begin
            // A stored start of zero reads as unset, as does the reset value.
            if (stable_q == '0) begin
              stable_d = item_i.now;
            end else if (stab_due_q) begin
              step_dn  = 1'b1;
              stable_d = '0;
            end
          end else begin
            stable_d = '0;
          end
        end
      end
      OP_MANUAL_UP:   step_up = 1'b1;
      OP_MANUAL_DOWN: step_dn = 1'b1;
      default: ;
    endcase
    if ((step_up && level_q < LevelMax) || (step_dn && level_q > LevelMin)) begin
      level_d  = step_up ? level_q + 1'b1 : level_q - 1'b1;
      up       = step_up;
      dn       = step_dn;
      last_d   = item_i.now;
      wsteps_d = (steps_eff == StepsSat) ? steps_eff : steps_eff + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      level_q     <= LevelMin;
      phase_q     <= PH_OFF;
      last_q      <= '0;
      wsteps_q    <= '0;
      wstart_q    <= '0;
      stable_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        level_q     <= level_d;
        phase_q     <= phase_d;
        last_q      <= last_d;
        wsteps_q    <= wsteps_d;
        wstart_q    <= wstart_d;
        stable_q    <= stable_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_en) begin
      renew_q    <= renew_d;
      intv_ok_q  <= intv_ok_d;
      stab_due_q <= stab_due_d;
    end
    if (commit) begin
      out_level_q <= level_d;
      out_phase_q <= phase_d;
      out_up_q    <= up;
      out_dn_q    <= dn;
      out_shut_q  <= shut;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign heater_level_o     = out_level_q;
  assign heater_phase_o     = out_phase_q;
  assign pulse_up_o         = out_up_q;
  assign pulse_down_o       = out_dn_q;
  assign shutdown_request_o = out_shut_q;

  a_commit_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_COMMIT |-> !empty_i)
    else $error("commit state without a queued word");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q >= LevelMin && level_q <= LevelMax)
    else $error("heater level out of range");

  a_single_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_up_q && out_dn_q) && !(out_shut_q && (out_up_q || out_dn_q)))
    else $error("conflicting result flags");

  a_level_moves_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (out_up_q -> level_q == $past(level_q) + 1'b1) &&
               (out_dn_q -> level_q == $past(level_q) - 1'b1))
    else $error("level moved without matching pulse");

endmodule

`default_nettype wire

[hw/rtl/heater_level_step_regulator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Heater level step regulator.
// Input words (operation, timestamp, temperatures, current) enter on the
// in_valid_i / in_ready_o channel. Each word gives exactly one result word on
// out_valid_o / out_ready_i: level, phase, up and down pulse requests and a
// shutdown request. Configuration registers are written on the cfg channel,
// index 0 to 7, and cfg_ready_o is always high; write them only while idle.
// A taken word passes the queue, then the step timer compare registers, then
// the result registers. The back end takes one word at a time and commits
// the state and the result once the output is free.
// A two-word queue sits between the classifier and the back end, so input
// words are still taken while a result waits for the receiver.
// When the receiver stalls, the result holds; once the queue is full,
// in_ready_o drops until the result is taken.
// Reset sets the level to 1, the phase to off, clears all timestamps and the
// step count, and loads the default configuration. No clearing pass is needed.

module heater_level_step_regulator
  import hlsr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [31:0]        time_ms_i,
  input  wire logic signed [11:0] inside_temp_i,
  input  wire logic               inside_valid_i,
  input  wire logic signed [11:0] exhaust_temp_i,
  input  wire logic               exhaust_valid_i,
  input  wire logic signed [15:0] heater_current_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [3:0]              heater_level_o,
  output logic [2:0]              heater_phase_o,
  output logic                    pulse_up_o,
  output logic                    pulse_down_o,
  output logic                    shutdown_request_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_addr_i,
  input  wire logic [15:0]        cfg_data_i
);

  cfg_t  cfg_q;
  logic  push, pop, full, empty;
  item_t push_item, head_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_SETPOINT:      cfg_q.setpoint             <= cfg_data_i[8:0];
        CFG_COLD_MARGIN:   cfg_q.cold_margin          <= cfg_data_i[7:0];
        CFG_HOT_MARGIN:    cfg_q.hot_margin           <= cfg_data_i[7:0];
        CFG_MIN_STEP_INTV: cfg_q.min_step_interval_s  <= cfg_data_i;
        CFG_STABILIZE_DUR: cfg_q.stabilize_duration_s <= cfg_data_i;
        CFG_STEP_QUOTA:    cfg_q.step_quota           <= cfg_data_i[7:0];
        CFG_EXH_WARN_LIM:  cfg_q.exh_warn_lim         <= signed'(cfg_data_i[11:0]);
        CFG_EXH_OFF_LIM:   cfg_q.exh_off_lim          <= signed'(cfg_data_i[11:0]);
        default: ;
      endcase
    end
  end

  hlsr_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .time_ms_i        (time_ms_i),
    .inside_temp_i    (inside_temp_i),
    .inside_valid_i   (inside_valid_i),
    .exhaust_temp_i   (exhaust_temp_i),
    .exhaust_valid_i  (exhaust_valid_i),
    .heater_current_i (heater_current_i),
    .cfg_i            (cfg_q),
    .full_i           (full),
    .push_o           (push),
    .item_o           (push_item)
  );

  hlsr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (head_item)
  );

  hlsr_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_i             (head_item),
    .empty_i            (empty),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .heater_level_o     (heater_level_o),
    .heater_phase_o     (heater_phase_o),
    .pulse_up_o         (pulse_up_o),
    .pulse_down_o       (pulse_down_o),
    .shutdown_request_o (shutdown_request_o)
  );

endmodule

`default_nettype wire
